>>> hdl/six_dof_tracker_record_decoder_core_macros.svh
// Assertion macros shared by the record decoder RTL.
`ifndef SIX_DOF_TRACKER_RECORD_DECODER_CORE_MACROS_SVH
`define SIX_DOF_TRACKER_RECORD_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rdc assertion failed");
`define RDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rdc assertion failed");
`else
`define RDC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RDC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/rdc_pkg.sv
package rdc_pkg;

    localparam int ByteW    = 8;
    localparam int GroupW   = 7;
    localparam int RecGroups = 15;
    localparam int PosCntW  = 4;
    localparam int PosW     = 21;
    localparam int AngW     = 14;

    typedef struct packed {
        logic [AngW-1:0]        roll_angle;
        logic [AngW-1:0]        yaw_angle;
        logic [AngW-1:0]        pitch_angle;
        logic signed [PosW-1:0] pos_z;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_x;
        logic [ByteW-1:0]       buttons;
    } t_result;

    localparam int ResW   = $bits(t_result);
    localparam int TdataW = ((ResW + 7) / 8) * 8;
    localparam int PadW   = TdataW - ResW;

endpackage

>>> hdl/rdc_framer.sv
`include "six_dof_tracker_record_decoder_core_macros.svh"

module rdc_framer
    import rdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_byte_valid,
    input  logic [ByteW-1:0] i_byte,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam logic [PosCntW-1:0] LastPos  = PosCntW'(RecGroups - 1);
    localparam logic [PosCntW-1:0] LimitPos = PosCntW'(RecGroups);

    logic [PosCntW-1:0] r_pos, n_pos;
    logic               r_in_record, n_in_record;
    logic [ByteW-1:0]   r_first;
    logic [GroupW-1:0]  r_groups [0:RecGroups-2];
    logic               w_flag;
    logic               w_store;
    logic [GroupW-1:0]  w_grp;

    assign w_flag = i_byte[ByteW-1];
    assign w_grp  = i_byte[GroupW-1:0];

    always_comb begin
        n_pos       = r_pos;
        n_in_record = r_in_record;
        w_store     = 1'b0;
        o_res_valid = 1'b0;
        if (i_byte_valid) begin
            if (w_flag) begin
                n_pos       = '0;
                n_in_record = 1'b1;
            end else if (r_in_record) begin
                if (r_pos >= LimitPos) begin
                    n_pos       = '0;
                    n_in_record = 1'b0;
                end else if (r_pos == LastPos) begin
                    n_pos       = '0;
                    n_in_record = 1'b0;
                    o_res_valid = 1'b1;
                end else begin
                    n_pos   = r_pos + PosCntW'(1);
                    w_store = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_in_record <= 1'b0;
            r_first     <= '0;
        end else begin
            r_pos       <= n_pos;
            r_in_record <= n_in_record;
            if (i_byte_valid && w_flag) begin
                r_first <= i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_groups[r_pos] <= w_grp;
        end
    end

    // last group arrives live with the completing item
    assign o_res.buttons     = r_first;
    assign o_res.pos_x       = {r_groups[0], r_groups[1], r_groups[2]};
    assign o_res.pos_y       = {r_groups[3], r_groups[4], r_groups[5]};
    assign o_res.pos_z       = {r_groups[6], r_groups[7], r_groups[8]};
    assign o_res.pitch_angle = {r_groups[9], r_groups[10]};
    assign o_res.yaw_angle   = {r_groups[11], r_groups[12]};
    assign o_res.roll_angle  = {r_groups[13], w_grp};

    `RDC_ASSERT_IMP(a_pos_in_record, i_clk, i_rst_n, r_pos != '0, r_in_record)
    `RDC_ASSERT_NXT(a_done_resets, i_clk, i_rst_n, o_res_valid, !r_in_record && r_pos == '0)
    `RDC_ASSERT_IMP(a_done_needs_record, i_clk, i_rst_n, o_res_valid, r_in_record && !w_flag)

endmodule

>>> hdl/rdc_out_buf.sv
`include "six_dof_tracker_record_decoder_core_macros.svh"

module rdc_out_buf
    import rdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_in_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_res;
            end
        end else if (i_push && !r_skid_valid) begin
            r_skid <= i_res;
        end
    end

    `RDC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `RDC_ASSERT_NXT(a_stall_to_skid, i_clk, i_rst_n,
        i_push && o_in_ready && r_out_valid && !i_ready, r_skid_valid)
    `RDC_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n,
        r_skid_valid && i_ready, r_out_valid && !r_skid_valid)

endmodule

>>> hdl/six_dof_tracker_record_decoder_core.sv
// Six-DOF tracker record decoder.
// Slave stream: one received serial byte per item in tdata[7:0]. A byte with
// bit 7 set opens a 16-byte record; stray bytes outside a record are dropped
// and a flag byte mid-record restarts framing.
// Master stream: one item per complete record, carrying buttons, three signed
// 21-bit positions (1/1000 unit) and three 14-bit angles (1/40 degree).
// Throughput: one byte per cycle while o_s_axis_tready is high, set by the single framing register stage.
// Result: the framer completes a record combinationally with its last byte,
// and the output register (or the skid register on a stall) captures it.
// Results sit in an output register backed by a one-item skid register; a
// stalled master side costs nothing until both hold an item, after which
// o_s_axis_tready stays low until the receiver takes an item.
// Reset (synchronous, active low) clears framing and empties both registers.
module six_dof_tracker_record_decoder_core
    import rdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [ByteW-1:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [7:0] buttons, [28:8] pos_x, [49:29] pos_y, [70:50] pos_z,
    // [84:71] pitch_angle, [98:85] yaw_angle, [112:99] roll_angle, rest zero
    output logic [TdataW-1:0] o_m_axis_tdata
);

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    rdc_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_accept),
        .i_byte       (i_s_axis_tdata),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    rdc_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_res_valid),
        .i_res      (w_res),
        .o_in_ready (o_s_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_res      (w_out),
        .i_ready    (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {{PadW{1'b0}}, w_out.roll_angle, w_out.yaw_angle,
                             w_out.pitch_angle, w_out.pos_z, w_out.pos_y,
                             w_out.pos_x, w_out.buttons};

endmodule
